### hw/rtl/scanline_edge_setup_core_defines.svh
// Assertion macros shared by the edge setup RTL.
// Included by modules that carry concurrent assertions; no other dependencies.
`ifndef SCANLINE_EDGE_SETUP_CORE_DEFINES_SVH
`define SCANLINE_EDGE_SETUP_CORE_DEFINES_SVH

// Checks that an implication holds at every clock edge outside reset.
`define SES_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Checks that the consequent holds in the cycle after the antecedent.
`define SES_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hw/rtl/ses_pkg.sv
// Package for the scanline edge setup core: fixed widths and 32-bit saturation.
// No dependencies.
`timescale 1ns / 1ps
package ses_pkg;
    localparam int CoordW = 20;
    localparam int ValW   = 32;
    localparam int LineW  = 16;
    localparam int QuoW   = 38;   // |xdist*2^16| < 2^37

    localparam logic signed [ValW-1:0] S32Max = 32'sh7FFF_FFFF;
    localparam logic signed [ValW-1:0] S32Min = 32'sh8000_0000;

    // Saturate a wide signed value to 32 bits.
    function automatic logic signed [ValW-1:0] sat32(input logic signed [79:0] v);
        logic signed [79:0] hi;
        logic signed [79:0] lo;
        begin
            hi = 80'(S32Max);
            lo = 80'(S32Min);
            if (v > hi)
                sat32 = S32Max;
            else if (v < lo)
                sat32 = S32Min;
            else
                sat32 = v[ValW-1:0];
        end
    endfunction
endpackage

### hw/rtl/scanline_edge_setup_core.sv
// Scanline edge setup core: top level, pipeline around the x-step divider.
// Depends on ses_pkg, ses_divider and scanline_edge_setup_core_defines.svh.
`timescale 1ns / 1ps
// One edge item per clock while the output does not stall, fully pipelined. The
// pipe has 44 register stages: one front stage, 39 divider stages (input capture
// plus one quotient bit per stage over 38 bits), three multiply/sum stages and
// the output register.
// Stalls on the output freeze the whole pipe, so in_ready = !out_valid || out_ready;
// bubbles are not squeezed out while the output waits.
// Coordinates are Q(20-S).S; line numbers are 16-bit integers and all other values signed Q16.16, both saturated.
// Flat edges (equal y) give x_step 0 and attr_step equal to the y gradient.
module scanline_edge_setup_core
    import ses_pkg::*;
#(
    parameter int SUBPIXEL_BITS = 4
)(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic signed [CoordW-1:0] top_x,
    input  logic signed [CoordW-1:0] top_y,
    input  logic signed [CoordW-1:0] bottom_x,
    input  logic signed [CoordW-1:0] bottom_y,
    input  logic signed [ValW-1:0]   attr_top_value,
    input  logic signed [ValW-1:0]   attr_x_gradient,
    input  logic signed [ValW-1:0]   attr_y_gradient,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic signed [LineW-1:0]  first_line,
    output logic signed [LineW-1:0]  end_line,
    output logic signed [ValW-1:0]   start_x,
    output logic signed [ValW-1:0]   x_step,
    output logic signed [ValW-1:0]   attr_start,
    output logic signed [ValW-1:0]   attr_step,
    output logic                     flat
);
    `include "scanline_edge_setup_core_defines.svh"

    localparam int S = SUBPIXEL_BITS;
    localparam int PW = S + 1;                    // yprestep width (unsigned)

    // Side data carried beside the divider.
    typedef struct packed {
        logic signed [LineW-1:0]  fl;
        logic signed [LineW-1:0]  el;
        logic [PW-1:0]            ypre;
        logic signed [CoordW-1:0] tx;
        logic signed [ValW-1:0]   av;
        logic signed [ValW-1:0]   gx;
        logic signed [ValW-1:0]   gy;
        logic                     flat;
    } side_t;
    localparam int TagW = $bits(side_t);

    // Whole pipe advances unless the output register is full and blocked.
    logic en;
    assign en       = !out_valid || out_ready;
    assign in_ready = en;

    // ---------------- stage 1: ceil, prestep, differences ----------------
    logic signed [CoordW+1:0] ty_c, by_c;
    logic signed [CoordW+1:0] ys_w, ye_w;
    assign ty_c = (CoordW+2)'(top_y) + (CoordW+2)'((1 << S) - 1);
    assign by_c = (CoordW+2)'(bottom_y) + (CoordW+2)'((1 << S) - 1);
    assign ys_w = ty_c >>> S;
    assign ye_w = by_c >>> S;

    function automatic logic signed [LineW-1:0] sat16(input logic signed [CoordW+1:0] v);
        begin
            if (v > (CoordW+2)'(32767))
                sat16 = 16'sh7FFF;
            else if (v < -(CoordW+2)'(32768))
                sat16 = 16'sh8000;
            else
                sat16 = v[LineW-1:0];
        end
    endfunction

    logic                     s1_v_reg;
    side_t                    s1_side_reg;
    logic signed [QuoW-1:0]   s1_num_reg;
    logic signed [CoordW:0]   s1_den_reg;

    logic signed [CoordW+S+1:0] ys_scaled;
    assign ys_scaled = ys_w <<< S;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_v_reg <= 1'b0;
        else if (en)
            s1_v_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_side_reg.fl   <= sat16(ys_w);
            s1_side_reg.el   <= sat16(ye_w);
            s1_side_reg.ypre <= PW'(ys_scaled - (CoordW+S+2)'(top_y));
            s1_side_reg.tx   <= top_x;
            s1_side_reg.av   <= attr_top_value;
            s1_side_reg.gx   <= attr_x_gradient;
            s1_side_reg.gy   <= attr_y_gradient;
            s1_side_reg.flat <= (bottom_y == top_y);
            s1_num_reg <= QuoW'((CoordW+1)'(bottom_x) - (CoordW+1)'(top_x)) <<< 16;
            s1_den_reg <= (CoordW+1)'(bottom_y) - (CoordW+1)'(top_y);
        end
    end

    // ---------------- divider ----------------
    logic                   dv_v;
    logic signed [ValW-1:0] dv_q;
    logic [TagW-1:0]        dv_tag;

    ses_divider #(.TagW(TagW)) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_valid (s1_v_reg),
        .dividend (s1_num_reg),
        .divisor  (s1_den_reg),
        .in_tag   (s1_side_reg),
        .out_valid(dv_v),
        .quotient (dv_q),
        .out_tag  (dv_tag)
    );

    side_t dv_side;
    logic signed [ValW-1:0] xs_d;
    assign dv_side = side_t'(dv_tag);
    assign xs_d = dv_side.flat ? '0 : dv_q;

    // ---------------- stage M1: xpre product, gx*xstep, gy*ypre ----------------
    logic                      m1_v_reg;
    side_t                     m1_side_reg;
    logic signed [ValW-1:0]    m1_xs_reg;
    logic signed [ValW+PW:0]   m1_xpp_reg;    // ypre * xstep
    logic signed [2*ValW-1:0]  m1_gxs_reg;    // gx * xstep
    logic signed [ValW+PW:0]   m1_gyp_reg;    // gy * ypre

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m1_v_reg <= 1'b0;
        else if (en)
            m1_v_reg <= dv_v;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            m1_side_reg <= dv_side;
            m1_xs_reg   <= xs_d;
            m1_xpp_reg  <= (ValW+PW+1)'(xs_d) * $signed({1'b0, dv_side.ypre});
            m1_gxs_reg  <= (2*ValW)'(dv_side.gx) * (2*ValW)'(xs_d);
            m1_gyp_reg  <= (ValW+PW+1)'(dv_side.gy) * $signed({1'b0, dv_side.ypre});
        end
    end

    // ---------------- stage M2: xstart, clamped xpre, astep ----------------
    logic signed [ValW+PW:0] xpre_w;
    assign xpre_w = m1_xpp_reg >>> S;

    logic                     m2_v_reg;
    side_t                    m2_side_reg;
    logic signed [ValW-1:0]   m2_xs_reg;
    logic signed [ValW-1:0]   m2_xst_reg;
    logic signed [ValW-1:0]   m2_xpc_reg;
    logic signed [ValW-1:0]   m2_ast_reg;
    logic signed [ValW+PW:0]  m2_gyp_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m2_v_reg <= 1'b0;
        else if (en)
            m2_v_reg <= m1_v_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            m2_side_reg <= m1_side_reg;
            m2_xs_reg   <= m1_xs_reg;
            m2_xst_reg  <= sat32(80'(xpre_w) + (80'(m1_side_reg.tx) <<< (16 - S)));
            m2_xpc_reg  <= sat32(80'(xpre_w));
            m2_ast_reg  <= sat32(80'(m1_side_reg.gy) + 80'(m1_gxs_reg >>> 16));
            m2_gyp_reg  <= m1_gyp_reg;
        end
    end

    // ---------------- stage M3: gx * clamped xpre ----------------
    logic                     m3_v_reg;
    side_t                    m3_side_reg;
    logic signed [ValW-1:0]   m3_xs_reg;
    logic signed [ValW-1:0]   m3_xst_reg;
    logic signed [ValW-1:0]   m3_ast_reg;
    logic signed [2*ValW-1:0] m3_gxp_reg;
    logic signed [ValW+PW:0]  m3_gyp_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m3_v_reg <= 1'b0;
        else if (en)
            m3_v_reg <= m2_v_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            m3_side_reg <= m2_side_reg;
            m3_xs_reg   <= m2_xs_reg;
            m3_xst_reg  <= m2_xst_reg;
            m3_ast_reg  <= m2_ast_reg;
            m3_gxp_reg  <= (2*ValW)'(m2_side_reg.gx) * (2*ValW)'(m2_xpc_reg);
            m3_gyp_reg  <= m2_gyp_reg;
        end
    end

    // ---------------- output register: attr_start sum ----------------
    logic signed [79:0] asum;
    assign asum = 80'(m3_side_reg.av) + 80'(m3_gxp_reg >>> 16) + 80'(m3_gyp_reg >>> S);

    logic                    out_v_reg;
    logic signed [LineW-1:0] fl_reg, el_reg;
    logic signed [ValW-1:0]  xst_reg, xs_reg, ast_reg, aat_reg;
    logic                    flat_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_v_reg <= 1'b0;
        else if (en)
            out_v_reg <= m3_v_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            fl_reg   <= m3_side_reg.fl;
            el_reg   <= m3_side_reg.el;
            xst_reg  <= m3_xst_reg;
            xs_reg   <= m3_xs_reg;
            aat_reg  <= sat32(asum);
            ast_reg  <= m3_ast_reg;
            flat_reg <= m3_side_reg.flat;
        end
    end

    assign out_valid  = out_v_reg;
    assign first_line = fl_reg;
    assign end_line   = el_reg;
    assign start_x    = xst_reg;
    assign x_step     = xs_reg;
    assign attr_start = aat_reg;
    assign attr_step  = ast_reg;
    assign flat       = flat_reg;

    // A flat result always carries a zero x step.
    `SES_ASSERT_IMP(a_flat_zero_step, clk, rst_n, out_valid && flat, x_step == '0, "flat edge with nonzero x step")
    // A stalled result holds its value.
    `SES_ASSERT_NEXT(a_hold_on_stall, clk, rst_n, out_valid && !out_ready, out_valid && $stable(start_x) && $stable(attr_start), "result changed while stalled")
    // A flat edge starts and ends on the same scanline.
    `SES_ASSERT_IMP(a_flat_lines, clk, rst_n, out_valid && flat, first_line == end_line, "flat edge with differing lines")
endmodule

### hw/rtl/ses_divider.sv
// Pipelined restoring divider, one quotient bit per stage, with stall.
// Depends on ses_pkg. Truncating signed quotient, saturated to 32 bits.
`timescale 1ns / 1ps
module ses_divider
    import ses_pkg::*;
#(
    parameter int TagW = 8
)(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   en,
    input  logic                   in_valid,
    input  logic signed [QuoW-1:0] dividend,
    input  logic signed [CoordW:0] divisor,
    input  logic [TagW-1:0]        in_tag,
    output logic                   out_valid,
    output logic signed [ValW-1:0] quotient,
    output logic [TagW-1:0]        out_tag
);
    localparam int N = QuoW;
    localparam int DW = CoordW + 1;

    typedef struct packed {
        logic [N-1:0]  rem_q;     // dividend bits shifting out, quotient in
        logic [DW:0]   rem;       // partial remainder
        logic [DW-1:0] den;
        logic          neg;
        logic [TagW-1:0] tag;
    } dstage_t;

    dstage_t      st_reg [0:N];
    logic [N:0]   v_reg;
    dstage_t      st_next [0:N];

    logic [N-1:0] a_mag;
    logic [DW-1:0] d_mag;
    assign a_mag = dividend[N-1] ? N'(-dividend) : N'(dividend);
    assign d_mag = divisor[DW-1] ? DW'(-divisor) : DW'(divisor);

    always_comb
    begin
        st_next[0].rem_q = a_mag;
        st_next[0].rem   = '0;
        st_next[0].den   = d_mag;
        st_next[0].neg   = dividend[N-1] ^ divisor[DW-1];
        st_next[0].tag   = in_tag;
        for (int i = 1; i <= N; i++)
        begin
            logic [DW:0] r;
            logic [DW+1:0] diff;
            r = {st_reg[i-1].rem[DW-1:0], st_reg[i-1].rem_q[N-1]};
            diff = {1'b0, r} - {2'b0, st_reg[i-1].den};
            st_next[i] = st_reg[i-1];
            if (!diff[DW+1])
            begin
                st_next[i].rem = diff[DW:0];
                st_next[i].rem_q = {st_reg[i-1].rem_q[N-2:0], 1'b1};
            end
            else
            begin
                st_next[i].rem = r;
                st_next[i].rem_q = {st_reg[i-1].rem_q[N-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else if (en)
            v_reg <= {v_reg[N-1:0], in_valid};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            st_reg[0] <= st_next[0];
            for (int i = 1; i <= N; i++)
                st_reg[i] <= st_next[i];
        end
    end

    logic signed [N:0] q_s;
    assign q_s = st_reg[N].neg ? -$signed({1'b0, st_reg[N].rem_q})
                               : $signed({1'b0, st_reg[N].rem_q});
    assign quotient  = sat32(80'(q_s));
    assign out_valid = v_reg[N];
    assign out_tag   = st_reg[N].tag;
endmodule

### tb/sv/scanline_edge_setup_core_checker.sv
// Checker for the scanline edge setup core: watches both channels, predicts
// each edge result and compares it field by field. Depends on ses_pkg.
`timescale 1ns / 1ps
module scanline_edge_setup_core_checker
    import ses_pkg::*;
#(
    parameter int SUBPIXEL_BITS = 4
)(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    input  logic                     in_ready,
    input  logic signed [CoordW-1:0] top_x,
    input  logic signed [CoordW-1:0] top_y,
    input  logic signed [CoordW-1:0] bottom_x,
    input  logic signed [CoordW-1:0] bottom_y,
    input  logic signed [ValW-1:0]   attr_top_value,
    input  logic signed [ValW-1:0]   attr_x_gradient,
    input  logic signed [ValW-1:0]   attr_y_gradient,
    input  logic                     out_valid,
    input  logic                     out_ready,
    input  logic signed [LineW-1:0]  first_line,
    input  logic signed [LineW-1:0]  end_line,
    input  logic signed [ValW-1:0]   start_x,
    input  logic signed [ValW-1:0]   x_step,
    input  logic signed [ValW-1:0]   attr_start,
    input  logic signed [ValW-1:0]   attr_step,
    input  logic                     flat,
    output int                       fail_count,
    output int                       pending
);
    typedef struct packed {
        logic signed [LineW-1:0] first_line;
        logic signed [LineW-1:0] end_line;
        logic signed [ValW-1:0]  start_x;
        logic signed [ValW-1:0]  x_step;
        logic signed [ValW-1:0]  attr_start;
        logic signed [ValW-1:0]  attr_step;
        logic                    flat;
    } edge_setup_t;

    localparam longint SatHi = 64'sd2147483647;
    localparam longint SatLo = -64'sd2147483648;

    edge_setup_t setup_q[$];

    // >>> on signed operands is floor division by 2^s
    function automatic longint clamp(longint v, longint lo, longint hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function automatic edge_setup_t predict_edge(
        longint tx, longint ty, longint bx, longint by_, longint av, longint gx, longint gy);
        edge_setup_t r;
        longint one, ys, ye, ypre, xstep, xpre, xs, xpre_c, ast, asp;
        one = longint'(1) <<< SUBPIXEL_BITS;
        ys = (ty + one - 1) >>> SUBPIXEL_BITS;
        ye = (by_ + one - 1) >>> SUBPIXEL_BITS;
        ypre = ys * one - ty;
        xstep = 0;
        if (by_ != ty)
            xstep = clamp(((bx - tx) * 65536) / (by_ - ty), SatLo, SatHi);
        xpre = (ypre * xstep) >>> SUBPIXEL_BITS;
        xs = clamp(tx * (longint'(1) <<< (16 - SUBPIXEL_BITS)) + xpre, SatLo, SatHi);
        xpre_c = clamp(xpre, SatLo, SatHi);
        ast = clamp(av + ((gx * xpre_c) >>> 16) + ((gy * ypre) >>> SUBPIXEL_BITS),
                    SatLo, SatHi);
        asp = clamp(gy + ((gx * xstep) >>> 16), SatLo, SatHi);
        r.first_line = LineW'(clamp(ys, -32768, 32767));
        r.end_line   = LineW'(clamp(ye, -32768, 32767));
        r.start_x    = ValW'(xs);
        r.x_step     = ValW'(xstep);
        r.attr_start = ValW'(ast);
        r.attr_step  = ValW'(asp);
        r.flat       = (by_ == ty);
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        edge_setup_t e;
        if (!rst_n)
        begin
            fail_count <= 0;
            pending    <= 0;
            setup_q.delete();
        end
        else
        begin
            if (in_valid && in_ready)
                setup_q.push_back(predict_edge(top_x, top_y, bottom_x, bottom_y,
                    attr_top_value, attr_x_gradient, attr_y_gradient));
            if (out_valid && out_ready)
            begin
                if (setup_q.size() == 0)
                begin
                    $error("edge result with nothing expected");
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    e = setup_q.pop_front();
                    if ({first_line, end_line, start_x, x_step, attr_start, attr_step, flat}
                        != e)
                        fail_count <= fail_count + 1;
                    if (first_line != e.first_line)
                        $error("first_line exp %0d got %0d", e.first_line, first_line);
                    if (end_line != e.end_line)
                        $error("end_line exp %0d got %0d", e.end_line, end_line);
                    if (start_x != e.start_x)
                        $error("start_x exp %0d got %0d", e.start_x, start_x);
                    if (x_step != e.x_step)
                        $error("x_step exp %0d got %0d", e.x_step, x_step);
                    if (attr_start != e.attr_start)
                        $error("attr_start exp %0d got %0d", e.attr_start, attr_start);
                    if (attr_step != e.attr_step)
                        $error("attr_step exp %0d got %0d", e.attr_step, attr_step);
                    if (flat != e.flat)
                        $error("flat exp %0d got %0d", e.flat, flat);
                end
            end
            pending <= setup_q.size();
        end
    end
endmodule

### tb/sv/scanline_edge_setup_core_tb.sv
// Testbench top for the scanline edge setup core: stimulus, back-pressure
// and verdict. Depends on ses_pkg, the core and its checker.
`timescale 1ns / 1ps
module scanline_edge_setup_core_tb
    import ses_pkg::*;
();

    localparam int NumRandom = 1630;
    localparam int Latency   = 60;     // pipe is 44 stages deep
    localparam longint CycleLimit = 400000;

    logic                     clk;
    logic                     rst_n;
    logic                     in_valid;
    logic                     in_ready;
    logic signed [CoordW-1:0] top_x, top_y, bottom_x, bottom_y;
    logic signed [ValW-1:0]   attr_top_value, attr_x_gradient, attr_y_gradient;
    logic                     out_valid;
    logic                     out_ready;
    logic signed [LineW-1:0]  first_line, end_line;
    logic signed [ValW-1:0]   start_x, x_step, attr_start, attr_step;
    logic                     flat;
    int                       fail_count;
    int                       pending;
    longint                   cycles = 0;
    bit                       hold_off;   // long receiver stall in progress

    scanline_edge_setup_core u_dut (.*);

    scanline_edge_setup_core_checker u_chk (.*);

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Watchdog: far above the slowest legal run.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CycleLimit)
        begin
            $display("scanline_edge_setup_core_tb: FAIL");
            $finish;
        end
    end

    // Receiver: random stall patterns, calm stretches, and one long hold-off.
    initial
    begin
        int mode;
        out_ready = 1'b0;
        hold_off = 1'b1;
        @(posedge rst_n);
        // Long hold-off while the sender keeps offering: fills the pipe.
        repeat (300) @(posedge clk);
        hold_off = 1'b0;
        forever
        begin
            mode = $urandom_range(0, 3);
            repeat ($urandom_range(20, 120))
            begin
                @(posedge clk);
                case (mode)
                    0: out_ready <= 1'b1;
                    1: out_ready <= ($urandom_range(0, 3) != 0);
                    2: out_ready <= ($urandom_range(0, 1) != 0);
                    default: out_ready <= ($urandom_range(0, 4) == 0);
                endcase
            end
        end
    end

    // Drive one edge item and wait until it is taken.
    task automatic send_edge(logic signed [CoordW-1:0] tx, ty, bx, by_,
                             logic signed [ValW-1:0] av, gx, gy);
        in_valid        <= 1'b1;
        top_x           <= tx;
        top_y           <= ty;
        bottom_x        <= bx;
        bottom_y        <= by_;
        attr_top_value  <= av;
        attr_x_gradient <= gx;
        attr_y_gradient <= gy;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    task automatic idle_gap(int n);
        if (n > 0)
        begin
            in_valid <= 1'b0;
            repeat (n) @(posedge clk);
        end
    endtask

    function automatic logic signed [CoordW-1:0] rand_coord(int kind);
        case (kind)
            0: return CoordW'($urandom);                          // full range
            1: return CoordW'($urandom_range(0, 4000)) - 2000;    // screen sized
            default: return $urandom_range(0, 1) ? 20'sh7FFFF : 20'sh80000;
        endcase
    endfunction

    function automatic logic signed [ValW-1:0] rand_val();
        case ($urandom_range(0, 3))
            0: return $urandom;
            1: return $urandom_range(0, 1) ? S32Max : S32Min;
            default: return ValW'($urandom_range(0, 1 << 20)) - (1 << 19);
        endcase
    endfunction

    initial
    begin
        logic signed [CoordW-1:0] ty;
        int burst;
        rst_n           = 1'b0;
        in_valid        = 1'b0;
        top_x           = '0;
        top_y           = '0;
        bottom_x        = '0;
        bottom_y        = '0;
        attr_top_value  = '0;
        attr_x_gradient = '0;
        attr_y_gradient = '0;
        repeat (7) @(posedge clk);
        rst_n = 1'b1;
        @(posedge clk);

        // Directed: extremes, flat edges, inverted edges, saturation.
        send_edge('0, '0, '0, '0, '0, '0, '0);
        send_edge(20'sd5, 20'sd3, 20'sd100, 20'sd3, 32'sd7, 32'sd9, 32'sd11);      // flat
        send_edge(20'sd16, 20'sd1, 20'sd48, 20'sd65, 32'sh10000, 32'sh8000, 32'sh4000);
        send_edge(20'sh80000, 20'sh80000, 20'sh7FFFF, 20'sh7FFFF, S32Max, S32Max, S32Max);
        send_edge(20'sh7FFFF, 20'sh80000, 20'sh80000, 20'sh80001, S32Min, S32Min, S32Min);
        send_edge(20'sh7FFFF, 20'sh7FFFF, 20'sh80000, 20'sh80000, S32Max, S32Min, S32Max);
        send_edge('0, 20'sd40, 20'sd100, 20'sd8, 32'sd0, 32'sh20000, -32'sh10000); // inverted
        send_edge(20'sh80000, 20'sd1, 20'sh7FFFF, 20'sd2, S32Max, S32Max, S32Min);
        send_edge(20'sh7FFFF, 20'sd15, 20'sh80000, 20'sd16, S32Min, S32Max, S32Max);
        send_edge(-20'sd17, -20'sd17, 20'sd33, -20'sd1, -32'sd1, -32'sd1, -32'sd1);
        send_edge(20'sd0, -20'sd1, 20'sd0, -20'sd1, S32Max, S32Max, S32Max);      // flat
        send_edge(20'sh7FFFF, 20'sh7FFFF, 20'sh7FFFF, 20'sh7FFFF, S32Min, S32Min, S32Min);
        send_edge(20'sh55555, 20'sh2AAAA, 20'sh2AAAA, 20'sh55555,
                  32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555);
        send_edge(20'sh2AAAA, 20'sh55555, 20'sh55555, 20'sh2AAAA,
                  32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA);

        // Random: bursts with gaps; mostly screen-sized edges, some wild ones.
        for (int i = 0; i < NumRandom; )
        begin
            burst = $urandom_range(1, 40);
            for (int j = 0; j < burst && i < NumRandom; j++, i++)
            begin
                ty = rand_coord($urandom_range(0, 9) == 0 ? 0 : 1);
                send_edge(rand_coord($urandom_range(0, 5) == 0 ? 0 : 1), ty,
                          rand_coord($urandom_range(0, 5) == 0 ? 2 : 1),
                          $urandom_range(0, 7) == 0 ? ty : rand_coord($urandom_range(0, 2)),
                          rand_val(), rand_val(), rand_val());
            end
            idle_gap($urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 25));
        end
        in_valid <= 1'b0;

        while (pending != 0 || hold_off)
            @(posedge clk);
        repeat (Latency) @(posedge clk);

        if (fail_count == 0 && pending == 0)
            $display("scanline_edge_setup_core_tb: PASS");
        else
            $display("scanline_edge_setup_core_tb: FAIL");
        $finish;
    end
endmodule

### scanline_edge_setup_core.f
+incdir+hw/rtl
hw/rtl/ses_pkg.sv
hw/rtl/ses_divider.sv
hw/rtl/scanline_edge_setup_core.sv
tb/sv/scanline_edge_setup_core_checker.sv
tb/sv/scanline_edge_setup_core_tb.sv
